// ===== hw/rtl/dtq_pkg.sv =====
// dtq_pkg: shared types, codes and default sizes for the deadline timer queue.
// Used by dtq_cell and deadline_timer_queue; depends on nothing.
package dtq_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int THREAD_BITS_DEF = 8;
	localparam int DEADLINE_W      = 64;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_POST   = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;

	localparam logic [2:0] ST_QUEUED      = 3'd0;
	localparam logic [2:0] ST_EXPIRED     = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_CANCELLED   = 3'd3;
	localparam logic [2:0] ST_NOT_PENDING = 3'd4;
	localparam logic [2:0] ST_WOKEN       = 3'd5;
	localparam logic [2:0] ST_NO_WAKE     = 3'd6;

	typedef struct packed {
		logic [1:0]            func;
		logic [31:0]           amount;
		logic [DEADLINE_W-1:0] deadline;
		logic [3:0]            event_slot;
		logic [7:0]            thread_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [7:0]            thread_id_res;
		logic [3:0]            event_slot_res;
		logic [DEADLINE_W-1:0] uptime;
		logic                  last;
	} res_t;

	// one operation per cycle across the whole chain
	typedef struct packed {
		logic drain_shift;
		logic remove;
		logic insert;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/dtq_cell.sv =====
// dtq_cell: one entry of the sorted timer chain (deadline, slot, waiter).
// Depends on dtq_pkg; instantiated in a row by deadline_timer_queue.
module dtq_cell #(
	parameter int SLOT_W   = 4,
	parameter int THREAD_W = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dtq_pkg::cell_ctl_t             ctl,
	input  logic [dtq_pkg::DEADLINE_W-1:0] new_deadline,
	input  logic [SLOT_W-1:0]              new_slot,
	input  logic [THREAD_W-1:0]            new_waiter,
	input  logic                           left_valid,
	input  logic [dtq_pkg::DEADLINE_W-1:0] left_deadline,
	input  logic [SLOT_W-1:0]              left_slot,
	input  logic [THREAD_W-1:0]            left_waiter,
	input  logic                           right_valid,
	input  logic [dtq_pkg::DEADLINE_W-1:0] right_deadline,
	input  logic [SLOT_W-1:0]              right_slot,
	input  logic [THREAD_W-1:0]            right_waiter,
	input  logic                           seen_in,
	input  logic                           before_in,
	output logic                           valid,
	output logic [dtq_pkg::DEADLINE_W-1:0] deadline,
	output logic [SLOT_W-1:0]              slot,
	output logic [THREAD_W-1:0]            waiter,
	output logic                           seen_out,
	output logic                           before_out
);

	logic                           valid_q;
	logic [dtq_pkg::DEADLINE_W-1:0] deadline_q;
	logic [SLOT_W-1:0]              slot_q;
	logic [THREAD_W-1:0]            waiter_q;
	logic                           match;
	logic                           new_first;
	logic                           take_right;
	logic                           take_left;
	logic                           take_new;

	assign match     = valid_q && (slot_q == new_slot);
	// new key sorts ahead of this entry; an empty cell counts as infinity
	assign new_first = !valid_q || (new_deadline < deadline_q) ||
		((new_deadline == deadline_q) && (new_slot < slot_q));

	assign seen_out   = seen_in || match;
	assign before_out = new_first;

	assign take_right = ctl.drain_shift || (ctl.remove && (seen_in || match));
	assign take_left  = ctl.insert && before_in;
	assign take_new   = ctl.insert && !before_in && new_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_right) begin
			valid_q <= right_valid;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_right) begin
			deadline_q <= right_deadline;
			slot_q     <= right_slot;
			waiter_q   <= right_waiter;
		end else if (take_left) begin
			deadline_q <= left_deadline;
			slot_q     <= left_slot;
			waiter_q   <= left_waiter;
		end else if (take_new) begin
			deadline_q <= new_deadline;
			slot_q     <= new_slot;
			waiter_q   <= new_waiter;
		end
	end

	assign valid    = valid_q;
	assign deadline = deadline_q;
	assign slot     = slot_q;
	assign waiter   = waiter_q;

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// deadline_timer_queue: 64-bit uptime counter plus a sorted chain of timer cells.
// Depends on dtq_pkg and dtq_cell.
//
// A command is taken when start is high and busy is low. Pending timers sit in
// a row of cells kept sorted by deadline, then slot, with the earliest at the
// head. A cancel, or the unused function code, is finished in S_EXEC, and so is
// a post that expires at once or names a slot out of range. A post that queues
// goes through S_EXEC, which pulls out any old entry for the slot, then
// S_INSERT, which shifts the new entry into place. A tick adds to uptime in
// S_EXEC; in S_DRAIN due timers then leave the head of the chain at one per
// cycle, or one no-wake beat is given if none is due. Each result beat is
// shown on result for a single cycle with strobe high, starting the cycle after
// it is formed; the receiver cannot stall, so wakes arrive on back-to-back
// cycles and must be taken as they come.
module deadline_timer_queue #(
	parameter int SLOTS       = dtq_pkg::SLOTS_DEF,
	parameter int THREAD_BITS = dtq_pkg::THREAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dtq_pkg::cmd_t cmd,
	output logic          strobe,
	output dtq_pkg::res_t result
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int DL_W   = dtq_pkg::DEADLINE_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_INSERT = 4'b0100,
		S_DRAIN  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	dtq_pkg::cmd_t      cmd_q;
	logic [DL_W-1:0]    uptime_q, uptime_d;
	logic               strobe_q, strobe_d;
	dtq_pkg::res_t      res_q, res_d;
	dtq_pkg::cell_ctl_t ctl;

	logic                ent_v  [SLOTS];
	logic [DL_W-1:0]     ent_dl [SLOTS];
	logic [SLOT_W-1:0]   ent_s  [SLOTS];
	logic [THREAD_BITS-1:0] ent_w [SLOTS];
	logic                seen   [SLOTS];
	logic                ahead  [SLOTS];

	logic                   l_v  [SLOTS];
	logic [DL_W-1:0]        l_dl [SLOTS];
	logic [SLOT_W-1:0]      l_s  [SLOTS];
	logic [THREAD_BITS-1:0] l_w  [SLOTS];
	logic                   r_v  [SLOTS];
	logic [DL_W-1:0]        r_dl [SLOTS];
	logic [SLOT_W-1:0]      r_s  [SLOTS];
	logic [THREAD_BITS-1:0] r_w  [SLOTS];
	logic                   s_in [SLOTS];
	logic                   b_in [SLOTS];

	logic [SLOT_W-1:0]      slot_idx;
	logic [THREAD_BITS-1:0] waiter_new;
	logic                   slot_ok;
	logic                   found;
	logic                   due0;
	logic                   due1;

	assign slot_idx   = SLOT_W'(cmd_q.event_slot);
	assign waiter_new = THREAD_BITS'(cmd_q.thread_id);
	assign slot_ok    = 32'(cmd_q.event_slot) < SLOTS;
	assign found      = seen[SLOTS-1];
	assign due0       = ent_v[0] && (ent_dl[0] <= uptime_q);
	assign due1       = ent_v[1] && (ent_dl[1] <= uptime_q);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign l_v[i]  = 1'b0;
			assign l_dl[i] = '0;
			assign l_s[i]  = '0;
			assign l_w[i]  = '0;
			assign s_in[i] = 1'b0;
			assign b_in[i] = 1'b0;
		end else begin : g_mid
			assign l_v[i]  = ent_v[i-1];
			assign l_dl[i] = ent_dl[i-1];
			assign l_s[i]  = ent_s[i-1];
			assign l_w[i]  = ent_w[i-1];
			assign s_in[i] = seen[i-1];
			assign b_in[i] = ahead[i-1];
		end
		if (i == SLOTS - 1) begin : g_tail
			assign r_v[i]  = 1'b0;
			assign r_dl[i] = '0;
			assign r_s[i]  = '0;
			assign r_w[i]  = '0;
		end else begin : g_body
			assign r_v[i]  = ent_v[i+1];
			assign r_dl[i] = ent_dl[i+1];
			assign r_s[i]  = ent_s[i+1];
			assign r_w[i]  = ent_w[i+1];
		end

		dtq_cell #(
			.SLOT_W   (SLOT_W),
			.THREAD_W (THREAD_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.new_deadline   (cmd_q.deadline),
			.new_slot       (slot_idx),
			.new_waiter     (waiter_new),
			.left_valid     (l_v[i]),
			.left_deadline  (l_dl[i]),
			.left_slot      (l_s[i]),
			.left_waiter    (l_w[i]),
			.right_valid    (r_v[i]),
			.right_deadline (r_dl[i]),
			.right_slot     (r_s[i]),
			.right_waiter   (r_w[i]),
			.seen_in        (s_in[i]),
			.before_in      (b_in[i]),
			.valid          (ent_v[i]),
			.deadline       (ent_dl[i]),
			.slot           (ent_s[i]),
			.waiter         (ent_w[i]),
			.seen_out       (seen[i]),
			.before_out     (ahead[i])
		);
	end

	always_comb begin
		state_d  = state_q;
		uptime_d = uptime_q;
		strobe_d = 1'b0;
		ctl      = '0;
		res_d.status         = dtq_pkg::ST_NO_WAKE;
		res_d.thread_id_res  = '0;
		res_d.event_slot_res = cmd_q.event_slot;
		res_d.uptime         = uptime_q;
		res_d.last           = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (cmd_q.func)
					dtq_pkg::FUNC_TICK: begin
						uptime_d = uptime_q + DL_W'(cmd_q.amount);
						state_d  = S_DRAIN;
					end
					dtq_pkg::FUNC_POST: begin
						if (!slot_ok) begin
							strobe_d     = 1'b1;
							res_d.status = dtq_pkg::ST_FULL;
						end else begin
							// drop any old entry for the slot first
							ctl.remove = 1'b1;
							if (cmd_q.deadline <= uptime_q) begin
								strobe_d     = 1'b1;
								res_d.status = dtq_pkg::ST_EXPIRED;
							end else begin
								state_d = S_INSERT;
							end
						end
					end
					dtq_pkg::FUNC_CANCEL: begin
						strobe_d   = 1'b1;
						ctl.remove = slot_ok;
						if (slot_ok && found) begin
							res_d.status = dtq_pkg::ST_CANCELLED;
						end else begin
							res_d.status = dtq_pkg::ST_NOT_PENDING;
						end
					end
					default: begin
						strobe_d             = 1'b1;
						res_d.event_slot_res = '0;
					end
				endcase
			end
			S_INSERT: begin
				ctl.insert   = 1'b1;
				strobe_d     = 1'b1;
				res_d.status = dtq_pkg::ST_QUEUED;
				state_d      = S_IDLE;
			end
			S_DRAIN: begin
				strobe_d = 1'b1;
				if (due0) begin
					// pop the head; stop once the next entry is not yet due
					ctl.drain_shift      = 1'b1;
					res_d.status         = dtq_pkg::ST_WOKEN;
					res_d.thread_id_res  = 8'(ent_w[0]);
					res_d.event_slot_res = 4'(ent_s[0]);
					res_d.last           = !due1;
					if (!due1) begin
						state_d = S_IDLE;
					end
				end else begin
					res_d.event_slot_res = '0;
					state_d              = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			uptime_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			uptime_q <= uptime_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && busy == 1'b0) begin
			cmd_q <= cmd;
		end
		res_q <= res_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	// chain stays packed toward the head (checked on the first two cells)
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		!ent_v[0] |-> !ent_v[1])
		else $error("timer chain has a hole at the head");

	// head never sorts after its neighbor
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_v[0] && ent_v[1]) |-> (ent_dl[0] <= ent_dl[1]))
		else $error("timer chain out of deadline order");

	// a result beat always comes from a working state
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) != S_IDLE))
		else $error("result beat without a command in flight");

	// wakes only come out of the drain
	a_wake_src: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (result.status == dtq_pkg::ST_WOKEN)) |-> ($past(state_q) == S_DRAIN))
		else $error("wake beat outside the drain");

	// a beat marked last ends the command
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> !busy)
		else $error("command still busy after its last beat");

endmodule

// ===== tb/sv/tb_deadline_timer_queue.sv =====
// tb_deadline_timer_queue: self-checking bench for the deadline timer queue.
// Depends on dtq_pkg and deadline_timer_queue; runs directed checks, then random ones.
`timescale 1ns / 1ps

module tb_deadline_timer_queue;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 24;
	localparam int NSLOT = dtq_pkg::SLOTS_DEF;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	dtq_pkg::cmd_t cmd;
	logic          strobe;
	dtq_pkg::res_t result;

	// predicted timer state
	logic [63:0] now_ns;
	logic [63:0] slot_when [NSLOT];
	logic [7:0]  slot_tid [NSLOT];
	logic        slot_armed [NSLOT];

	dtq_pkg::res_t due_results[$];
	int   bad_beats;
	int   beats_in;
	int   gap_pct;
	int   quiet_cycles;

	deadline_timer_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic dtq_pkg::res_t one_result(input logic [2:0] st,
			input logic [3:0] slot);
		dtq_pkg::res_t r;
		r = '0;
		r.status = st;
		r.event_slot_res = slot;
		r.uptime = now_ns;
		r.last = 1'b1;
		return r;
	endfunction

	// Apply one accepted command to the predicted state and queue its results.
	function automatic void advance_timers(input dtq_pkg::cmd_t c);
		dtq_pkg::res_t r;
		int   best;
		int   n_due;
		case (c.func)
			dtq_pkg::FUNC_TICK: begin
				now_ns = now_ns + 64'(c.amount);
				n_due = 0;
				for (int i = 0; i < NSLOT; i++)
					if (slot_armed[i] && slot_when[i] <= now_ns)
						n_due++;
				if (n_due == 0)
					due_results.push_back(one_result(dtq_pkg::ST_NO_WAKE, 4'd0));
				for (int k = 0; k < n_due; k++) begin
					best = -1;
					for (int i = 0; i < NSLOT; i++) begin
						if (slot_armed[i] && slot_when[i] <= now_ns) begin
							// strict compare keeps ties on the lower slot
							if (best < 0)
								best = i;
							else if (slot_when[i] < slot_when[best])
								best = i;
						end
					end
					slot_armed[best] = 1'b0;
					r = '0;
					r.status = dtq_pkg::ST_WOKEN;
					r.thread_id_res = slot_tid[best];
					r.event_slot_res = 4'(best);
					r.uptime = now_ns;
					r.last = (k == n_due - 1);
					due_results.push_back(r);
				end
			end
			dtq_pkg::FUNC_POST: begin
				if (int'(c.event_slot) >= NSLOT) begin
					due_results.push_back(one_result(dtq_pkg::ST_FULL, c.event_slot));
				end else if (c.deadline <= now_ns) begin
					slot_when[c.event_slot] = c.deadline;
					slot_armed[c.event_slot] = 1'b0;
					due_results.push_back(one_result(dtq_pkg::ST_EXPIRED, c.event_slot));
				end else begin
					slot_when[c.event_slot] = c.deadline;
					slot_tid[c.event_slot] = c.thread_id;
					slot_armed[c.event_slot] = 1'b1;
					due_results.push_back(one_result(dtq_pkg::ST_QUEUED, c.event_slot));
				end
			end
			dtq_pkg::FUNC_CANCEL: begin
				if (int'(c.event_slot) < NSLOT && slot_armed[c.event_slot]) begin
					slot_armed[c.event_slot] = 1'b0;
					due_results.push_back(one_result(dtq_pkg::ST_CANCELLED, c.event_slot));
				end else begin
					due_results.push_back(one_result(dtq_pkg::ST_NOT_PENDING, c.event_slot));
				end
			end
			default: begin
				due_results.push_back(one_result(dtq_pkg::ST_NO_WAKE, 4'd0));
			end
		endcase
	endfunction

	function automatic dtq_pkg::cmd_t mk_cmd(input logic [1:0] func,
			input logic [31:0] amount, input logic [63:0] deadline,
			input logic [3:0] slot, input logic [7:0] tid);
		dtq_pkg::cmd_t c;
		c.func = func;
		c.amount = amount;
		c.deadline = deadline;
		c.event_slot = slot;
		c.thread_id = tid;
		return c;
	endfunction

	// Hold start until the beat is taken; leave it high unless a gap is drawn.
	task automatic send_cmd(input dtq_pkg::cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		advance_timers(c);
		beats_in++;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic test_idle_ops();
		send_cmd(mk_cmd(dtq_pkg::FUNC_TICK, 32'd0, 64'd0, 4'd0, 8'd0));
		send_cmd(mk_cmd(FUNC_SPARE, $urandom, {$urandom, $urandom}, 4'd5, 8'h5A));
		send_cmd(mk_cmd(dtq_pkg::FUNC_CANCEL, 32'd0, 64'd0, 4'd0, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, 64'd0, 4'd0, 8'h3C));
	endtask

	task automatic test_post_extremes();
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, '1, 4'd15, 8'hFF));
		send_cmd(mk_cmd(dtq_pkg::FUNC_TICK, 32'hFFFF_FFFF, 64'd0, 4'd0, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns, 4'd3, 8'h33));
	endtask

	task automatic test_repost_cancel();
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd100, 4'd3, 8'h11));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd50, 4'd3, 8'h22));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd20, 4'd9, 8'h99));
		send_cmd(mk_cmd(dtq_pkg::FUNC_CANCEL, 32'd0, 64'd0, 4'd9, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_CANCEL, 32'd0, 64'd0, 4'd9, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd10, 4'd2, 8'hAA));
		// past deadline on a pending slot disarms it
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns, 4'd2, 8'h55));
	endtask

	task automatic test_wake_order();
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd50, 4'd7, 8'h77));
		send_cmd(mk_cmd(dtq_pkg::FUNC_POST, 32'd0, now_ns + 64'd60, 4'd1, 8'h01));
		send_cmd(mk_cmd(dtq_pkg::FUNC_TICK, 32'd60, 64'd0, 4'd0, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_CANCEL, 32'd0, 64'd0, 4'd15, 8'd0));
		send_cmd(mk_cmd(dtq_pkg::FUNC_TICK, 32'd1, 64'd0, 4'd0, 8'd0));
	endtask

	// Mostly bursts of posts followed by a tick that drains some of them.
	task automatic test_random(input int pct, input int items);
		int          stop_at;
		int          n_post;
		logic [63:0] dl;
		logic [63:0] prev_dl;
		logic [3:0]  s;
		logic [31:0] amt;
		gap_pct = pct;
		stop_at = beats_in + items;
		prev_dl = now_ns + 64'd1;
		while (beats_in < stop_at) begin
			if ($urandom_range(99) < 70) begin
				n_post = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 6);
				for (int j = 0; j < n_post; j++) begin
					s = (n_post == 16) ? 4'(j) : 4'($urandom_range(15));
					case ($urandom_range(9))
						0: dl = (now_ns > 64'd500) ? now_ns - 64'($urandom_range(500)) : 64'd0;
						1: dl = prev_dl;
						default: dl = now_ns + 64'($urandom_range(1, 3000));
					endcase
					if (n_post != 16 && $urandom_range(9) == 0)
						send_cmd(mk_cmd(dtq_pkg::FUNC_CANCEL, $urandom, dl, s, 8'($urandom)));
					else
						send_cmd(mk_cmd(dtq_pkg::FUNC_POST, $urandom, dl, s, 8'($urandom)));
					prev_dl = dl;
				end
				amt = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(0, 3500));
				send_cmd(mk_cmd(dtq_pkg::FUNC_TICK, amt, {$urandom, $urandom},
					4'($urandom), 8'($urandom)));
			end else begin
				send_cmd(mk_cmd(2'($urandom_range(3)), $urandom, {$urandom, $urandom},
					4'($urandom_range(15)), 8'($urandom)));
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		dtq_pkg::res_t want;
		if (arst_n && strobe === 1'b1) begin
			if (due_results.size() == 0) begin
				bad_beats++;
				if (bad_beats <= 10)
					$display("unexpected beat: st %0d tid %h slot %0d up %h last %b",
						result.status, result.thread_id_res, result.event_slot_res,
						result.uptime, result.last);
			end else begin
				want = due_results.pop_front();
				if (result.status !== want.status ||
						result.thread_id_res !== want.thread_id_res ||
						result.event_slot_res !== want.event_slot_res ||
						result.uptime !== want.uptime ||
						result.last !== want.last) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("mismatch: exp %0d %h %0d %h %b, got %0d %h %0d %h %b",
							want.status, want.thread_id_res, want.event_slot_res,
							want.uptime, want.last, result.status, result.thread_id_res,
							result.event_slot_res, result.uptime, result.last);
				end
			end
		end
	end

	// count cycles in which no beat moves either way
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || strobe === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_deadline_timer_queue failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		now_ns = '0;
		bad_beats = 0;
		beats_in = 0;
		gap_pct = 0;
		quiet_cycles = 0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_when[i] = '0;
			slot_tid[i] = '0;
			slot_armed[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ops();
		test_post_extremes();
		test_repost_cancel();
		test_wake_order();
		test_random(36, 150);
		test_random(70, 150);
		test_random(0, 140);
		start <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_beats == 0 && due_results.size() == 0)
			$display("tb_deadline_timer_queue passed");
		else
			$display("tb_deadline_timer_queue failed");
		$finish;
	end

endmodule
